// ===== sv/tscl_pkg.sv =====
// Shared types, constants and helper functions for the tile sum classifier.
// Used by the top level and the testbench; depends on nothing.
`default_nettype none

package tscl_pkg;

    localparam int MAX_TILES_ACROSS = 128;
    localparam int MAX_TILES_DOWN   = 128;
    localparam int MAX_TILE_SIDE    = 64;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 20;
    localparam int CLASS_W = 2;
    localparam int POS_W   = 7;
    localparam int TW_W    = 7;
    localparam int TA_W    = 8;
    localparam int COL_W   = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
    localparam int ROW_W   = (MAX_TILES_DOWN > 1) ? $clog2(MAX_TILES_DOWN) : 1;
    localparam int SIDE_W  = (MAX_TILE_SIDE > 1) ? $clog2(MAX_TILE_SIDE) : 1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [TW_W-1:0]  TILE_WIDTH_RST     = 7'd20;
    localparam logic [TW_W-1:0]  TILE_HEIGHT_RST    = 7'd20;
    localparam logic [TA_W-1:0]  TILES_ACROSS_RST   = 8'd40;
    localparam logic [TA_W-1:0]  TILES_DOWN_RST     = 8'd30;
    localparam logic [SUM_W-1:0] LOW_THRESHOLD_RST  = 20'd510;
    localparam logic [SUM_W-1:0] HIGH_THRESHOLD_RST = 20'd4590;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TILE_WIDTH     = 3'd0,
        CFG_TILE_HEIGHT    = 3'd1,
        CFG_TILES_ACROSS   = 3'd2,
        CFG_TILES_DOWN     = 3'd3,
        CFG_LOW_THRESHOLD  = 3'd4,
        CFG_HIGH_THRESHOLD = 3'd5
    } cfg_index_t;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_SPARSE = 2'd0,
        CLASS_DENSE  = 2'd1,
        CLASS_MID    = 2'd2
    } tile_class_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    // last counter value of a clamped size register
    function automatic logic [SIDE_W-1:0] side_last(input logic [TW_W-1:0] v);
        if (v == '0) return '0;
        if (32'(v) > MAX_TILE_SIDE) return SIDE_W'(MAX_TILE_SIDE - 1);
        return SIDE_W'(v - TW_W'(1));
    endfunction

    function automatic logic [COL_W-1:0] across_last(input logic [TA_W-1:0] v);
        if (v == '0) return '0;
        if (32'(v) > MAX_TILES_ACROSS) return COL_W'(MAX_TILES_ACROSS - 1);
        return COL_W'(v - TA_W'(1));
    endfunction

    function automatic logic [ROW_W-1:0] down_last(input logic [TA_W-1:0] v);
        if (v == '0) return '0;
        if (32'(v) > MAX_TILES_DOWN) return ROW_W'(MAX_TILES_DOWN - 1);
        return ROW_W'(v - TA_W'(1));
    endfunction

endpackage

`default_nettype wire

// ===== sv/tscl_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Holds the per column partial tile sums; no package dependency.
`default_nettype none

module tscl_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/tile_sum_three_level_classifier_unit.sv =====
// Top level of the tile sum classifier: position counters, accumulators,
// classification and the result register. Uses tscl_pkg and tscl_ram.
//
// One pixel is accepted every cycle while the result register is free or being
// drained; a tile's result appears in the cycle after its bottom right pixel is
// accepted. The tile row's partial sums live in a column sum RAM with a
// registered read that is addressed ahead with the next tile column, and a
// write-to-read forward covers the single column case. Per entry valid bits
// make the RAM read as zero after reset, so there is no clearing pass.
`default_nettype none

module tile_sum_three_level_classifier_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [tscl_pkg::PIX_W-1:0]         s_pixel_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [tscl_pkg::CLASS_W-1:0]       m_tile_class,
    output logic      [tscl_pkg::POS_W-1:0]         m_tile_column,
    output logic      [tscl_pkg::POS_W-1:0]         m_tile_row,
    output logic      [tscl_pkg::SUM_W-1:0]         m_tile_total,
    output logic                                    m_frame_done,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tscl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tscl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SUM_W  = tscl_pkg::SUM_W;
    localparam int COL_W  = tscl_pkg::COL_W;
    localparam int ROW_W  = tscl_pkg::ROW_W;
    localparam int SIDE_W = tscl_pkg::SIDE_W;
    localparam int POS_W  = tscl_pkg::POS_W;

    logic [tscl_pkg::TW_W-1:0] tile_width_reg, tile_height_reg;
    logic [tscl_pkg::TA_W-1:0] tiles_across_reg, tiles_down_reg;
    logic [SUM_W-1:0]          low_threshold_reg, high_threshold_reg;

    logic [SUM_W-1:0]  running_sum_reg, running_sum_next;
    logic [SIDE_W-1:0] x_in_tile_reg, x_in_tile_next;
    logic [SIDE_W-1:0] y_in_tile_reg, y_in_tile_next;
    logic [COL_W-1:0]  tile_x_reg, tile_x_next;
    logic [ROW_W-1:0]  tile_y_reg, tile_y_next;

    logic [tscl_pkg::MAX_TILES_ACROSS-1:0] col_valid_reg;
    logic                                  rd_valid_reg;
    logic                                  fwd_hit_reg;
    logic [SUM_W-1:0]                      fwd_data_reg;

    logic                   m_valid_reg;
    tscl_pkg::tile_class_t  m_class_reg;
    logic [POS_W-1:0]       m_column_reg, m_row_reg;
    logic [SUM_W-1:0]       m_total_reg;
    logic                   m_done_reg;

    logic [SIDE_W-1:0] tw_last, th_last;
    logic [COL_W-1:0]  ta_last;
    logic [ROW_W-1:0]  td_last;
    logic              x_end, y_end, tx_end, ty_end, emit, accept;
    logic [SUM_W-1:0]  row_sum, col_sum, total, ram_rdata, ram_wdata;
    logic              ram_we;
    logic [COL_W-1:0]  ram_raddr;
    tscl_pkg::tile_class_t tile_class;

    assign tw_last = tscl_pkg::side_last(tile_width_reg);
    assign th_last = tscl_pkg::side_last(tile_height_reg);
    assign ta_last = tscl_pkg::across_last(tiles_across_reg);
    assign td_last = tscl_pkg::down_last(tiles_down_reg);

    assign x_end  = x_in_tile_reg >= tw_last;
    assign y_end  = y_in_tile_reg >= th_last;
    assign tx_end = tile_x_reg >= ta_last;
    assign ty_end = tile_y_reg >= td_last;
    assign emit   = x_end && y_end;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign row_sum = tscl_pkg::sat_add(running_sum_reg, SUM_W'(s_pixel_value));
    assign col_sum = fwd_hit_reg  ? fwd_data_reg :
                     rd_valid_reg ? ram_rdata    : '0;
    assign total   = tscl_pkg::sat_add(col_sum, row_sum);

    always_comb begin
        priority if (total < low_threshold_reg) begin
            tile_class = tscl_pkg::CLASS_SPARSE;
        end else if (total > high_threshold_reg) begin
            tile_class = tscl_pkg::CLASS_DENSE;
        end else begin
            tile_class = tscl_pkg::CLASS_MID;
        end
    end

    always_comb begin
        running_sum_next = running_sum_reg;
        x_in_tile_next   = x_in_tile_reg;
        y_in_tile_next   = y_in_tile_reg;
        tile_x_next      = tile_x_reg;
        tile_y_next      = tile_y_reg;
        if (accept) begin
            if (!x_end) begin
                running_sum_next = row_sum;
                x_in_tile_next   = x_in_tile_reg + SIDE_W'(1);
            end else begin
                running_sum_next = '0;
                x_in_tile_next   = '0;
                if (!tx_end) begin
                    tile_x_next = tile_x_reg + COL_W'(1);
                end else begin
                    tile_x_next = '0;
                    if (!y_end) begin
                        y_in_tile_next = y_in_tile_reg + SIDE_W'(1);
                    end else begin
                        y_in_tile_next = '0;
                        tile_y_next    = ty_end ? '0 : tile_y_reg + ROW_W'(1);
                    end
                end
            end
        end
    end

    assign ram_we    = accept && x_end;
    assign ram_wdata = y_end ? '0 : total;
    assign ram_raddr = tile_x_next;

    tscl_ram #(
        .WIDTH (SUM_W),
        .DEPTH (tscl_pkg::MAX_TILES_ACROSS)
    ) u_col_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (tile_x_reg),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_width_reg     <= tscl_pkg::TILE_WIDTH_RST;
            tile_height_reg    <= tscl_pkg::TILE_HEIGHT_RST;
            tiles_across_reg   <= tscl_pkg::TILES_ACROSS_RST;
            tiles_down_reg     <= tscl_pkg::TILES_DOWN_RST;
            low_threshold_reg  <= tscl_pkg::LOW_THRESHOLD_RST;
            high_threshold_reg <= tscl_pkg::HIGH_THRESHOLD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tscl_pkg::CFG_TILE_WIDTH:     tile_width_reg     <= cfg_data[tscl_pkg::TW_W-1:0];
                tscl_pkg::CFG_TILE_HEIGHT:    tile_height_reg    <= cfg_data[tscl_pkg::TW_W-1:0];
                tscl_pkg::CFG_TILES_ACROSS:   tiles_across_reg   <= cfg_data[tscl_pkg::TA_W-1:0];
                tscl_pkg::CFG_TILES_DOWN:     tiles_down_reg     <= cfg_data[tscl_pkg::TA_W-1:0];
                tscl_pkg::CFG_LOW_THRESHOLD:  low_threshold_reg  <= cfg_data[SUM_W-1:0];
                tscl_pkg::CFG_HIGH_THRESHOLD: high_threshold_reg <= cfg_data[SUM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg <= '0;
            x_in_tile_reg   <= '0;
            y_in_tile_reg   <= '0;
            tile_x_reg      <= '0;
            tile_y_reg      <= '0;
            col_valid_reg   <= '0;
            rd_valid_reg    <= 1'b0;
            fwd_hit_reg     <= 1'b0;
        end else begin
            running_sum_reg <= running_sum_next;
            x_in_tile_reg   <= x_in_tile_next;
            y_in_tile_reg   <= y_in_tile_next;
            tile_x_reg      <= tile_x_next;
            tile_y_reg      <= tile_y_next;
            if (ram_we) begin
                col_valid_reg[tile_x_reg] <= 1'b1;
            end
            rd_valid_reg <= col_valid_reg[ram_raddr];
            fwd_hit_reg  <= ram_we && (tile_x_reg == ram_raddr);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= ram_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_class_reg  <= tile_class;
            m_column_reg <= POS_W'(tile_x_reg);
            m_row_reg    <= POS_W'(tile_y_reg);
            m_total_reg  <= total;
            m_done_reg   <= tx_end && ty_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tile_class  = m_class_reg;
    assign m_tile_column = m_column_reg;
    assign m_tile_row    = m_row_reg;
    assign m_tile_total  = m_total_reg;
    assign m_frame_done  = m_done_reg;

    a_rise_from_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(accept))
        else $error("result appeared without an accepted item");

    a_col_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> col_valid_reg[$past(tile_x_reg)])
        else $error("written column sum not marked valid");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && emit |=> m_valid_reg && (m_total_reg == $past(total)))
        else $error("tile result not loaded");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(x_in_tile_reg) && $stable(tile_x_reg)
                    && $stable(running_sum_reg))
        else $error("position or sum moved without an item");

endmodule

`default_nettype wire

// ===== tb/tile_sum_three_level_classifier_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tile_sum_three_level_classifier_unit: drives pixels,
// config writes and result back-pressure, and checks each tile against a predictor.
// Depends on tscl_pkg and the RTL top level only.

module tile_sum_three_level_classifier_unit_test;

    localparam int PIX_W            = tscl_pkg::PIX_W;
    localparam int SUM_W            = tscl_pkg::SUM_W;
    localparam int CLASS_W          = tscl_pkg::CLASS_W;
    localparam int POS_W            = tscl_pkg::POS_W;
    localparam int TW_W             = tscl_pkg::TW_W;
    localparam int TA_W             = tscl_pkg::TA_W;
    localparam int COL_W            = tscl_pkg::COL_W;
    localparam int ROW_W            = tscl_pkg::ROW_W;
    localparam int SIDE_W           = tscl_pkg::SIDE_W;
    localparam int CFG_INDEX_W      = tscl_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W       = tscl_pkg::CFG_DATA_W;
    localparam int MAX_TILES_ACROSS = tscl_pkg::MAX_TILES_ACROSS;
    localparam int MAX_TILES_DOWN   = tscl_pkg::MAX_TILES_DOWN;
    localparam int MAX_TILE_SIDE    = tscl_pkg::MAX_TILE_SIDE;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PIXELS = 1040;
    localparam int STEADY_TAIL   = 250;
    localparam int SHOWN_ERRORS  = 10;
    localparam int SUM_CEILING   = 1044480;
    localparam int FULL_ROWS     = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef enum int {MIX_RANDOM, MIX_EXTREME, MIX_DIM, MIX_FULL} pixel_mix_t;

    typedef struct {
        tscl_pkg::tile_class_t cls;
        logic [POS_W-1:0]      column;
        logic [POS_W-1:0]      row;
        logic [SUM_W-1:0]      total;
        logic                  done;
    } tile_result_t;

    class tile_scoreboard;
        logic [TW_W-1:0]   width_reg;
        logic [TW_W-1:0]   height_reg;
        logic [TA_W-1:0]   across_reg;
        logic [TA_W-1:0]   down_reg;
        logic [SUM_W-1:0]  low_reg;
        logic [SUM_W-1:0]  high_reg;
        logic [SUM_W-1:0]  col_sum [MAX_TILES_ACROSS];
        logic [SUM_W-1:0]  row_sum;
        logic [SIDE_W-1:0] x_pos;
        logic [SIDE_W-1:0] y_pos;
        logic [COL_W-1:0]  tile_x;
        logic [ROW_W-1:0]  tile_y;
        tile_result_t      expected_tiles [$];
        int                errors;

        function new();
            width_reg  = tscl_pkg::TILE_WIDTH_RST;
            height_reg = tscl_pkg::TILE_HEIGHT_RST;
            across_reg = tscl_pkg::TILES_ACROSS_RST;
            down_reg   = tscl_pkg::TILES_DOWN_RST;
            low_reg    = tscl_pkg::LOW_THRESHOLD_RST;
            high_reg   = tscl_pkg::HIGH_THRESHOLD_RST;
            foreach (col_sum[i]) col_sum[i] = '0;
            row_sum = '0;
            x_pos   = '0;
            y_pos   = '0;
            tile_x  = '0;
            tile_y  = '0;
            errors  = 0;
        endfunction

        function int clip_size(int v, int hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function logic [SUM_W-1:0] add_clip(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
            logic [SUM_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
        endfunction

        function int tile_area();
            return clip_size(int'(width_reg), MAX_TILE_SIDE)
                   * clip_size(int'(height_reg), MAX_TILE_SIDE);
        endfunction

        function int pending();
            return expected_tiles.size();
        endfunction

        function void fail_note(string msg);
            errors++;
            if (errors <= SHOWN_ERRORS) $display("%s", msg);
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                tscl_pkg::CFG_TILE_WIDTH:     width_reg  = d[TW_W-1:0];
                tscl_pkg::CFG_TILE_HEIGHT:    height_reg = d[TW_W-1:0];
                tscl_pkg::CFG_TILES_ACROSS:   across_reg = d[TA_W-1:0];
                tscl_pkg::CFG_TILES_DOWN:     down_reg   = d[TA_W-1:0];
                tscl_pkg::CFG_LOW_THRESHOLD:  low_reg    = d[SUM_W-1:0];
                tscl_pkg::CFG_HIGH_THRESHOLD: high_reg   = d[SUM_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix);
            int               tw;
            int               th;
            int               ta;
            int               td;
            bit               x_end;
            bit               y_end;
            bit               tx_end;
            bit               ty_end;
            logic [SUM_W-1:0] total;
            tile_result_t     r;
            tw = clip_size(int'(width_reg), MAX_TILE_SIDE);
            th = clip_size(int'(height_reg), MAX_TILE_SIDE);
            ta = clip_size(int'(across_reg), MAX_TILES_ACROSS);
            td = clip_size(int'(down_reg), MAX_TILES_DOWN);
            x_end  = int'(x_pos) >= tw - 1;
            y_end  = int'(y_pos) >= th - 1;
            tx_end = int'(tile_x) >= ta - 1;
            ty_end = int'(tile_y) >= td - 1;
            row_sum = add_clip(row_sum, SUM_W'(pix));
            if (x_end) begin
                total   = add_clip(col_sum[tile_x], row_sum);
                row_sum = '0;
                if (y_end) begin
                    if (total < low_reg) r.cls = tscl_pkg::CLASS_SPARSE;
                    else if (total > high_reg) r.cls = tscl_pkg::CLASS_DENSE;
                    else r.cls = tscl_pkg::CLASS_MID;
                    r.column = POS_W'(tile_x);
                    r.row    = POS_W'(tile_y);
                    r.total  = total;
                    r.done   = tx_end && ty_end;
                    expected_tiles.push_back(r);
                    col_sum[tile_x] = '0;
                end else begin
                    col_sum[tile_x] = total;
                end
            end
            if (!x_end) begin
                x_pos++;
            end else begin
                x_pos = '0;
                if (!tx_end) begin
                    tile_x++;
                end else begin
                    tile_x = '0;
                    if (!y_end) begin
                        y_pos++;
                    end else begin
                        y_pos = '0;
                        if (!ty_end) tile_y++;
                        else tile_y = '0;
                    end
                end
            end
        endfunction

        function void check_tile(logic [CLASS_W-1:0] cls, logic [POS_W-1:0] column,
                                 logic [POS_W-1:0] row, logic [SUM_W-1:0] total,
                                 logic done);
            tile_result_t e;
            if (expected_tiles.size() == 0) begin
                fail_note($sformatf("unexpected tile: class %0d col %0d row %0d total %0d %0d",
                                    cls, column, row, total, done));
                return;
            end
            e = expected_tiles.pop_front();
            if (cls !== e.cls || column !== e.column || row !== e.row ||
                total !== e.total || done !== e.done) begin
                fail_note($sformatf("tile mismatch: exp class %0d col %0d row %0d total %0d %0d",
                                    e.cls, e.column, e.row, e.total, e.done));
                if (errors <= SHOWN_ERRORS)
                    $display("                got class %0d col %0d row %0d total %0d %0d",
                             cls, column, row, total, done);
            end
        endfunction

        function void close();
            if (expected_tiles.size() != 0)
                fail_note($sformatf("%0d tiles never arrived", expected_tiles.size()));
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [PIX_W-1:0]       s_pixel_value;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [CLASS_W-1:0]     m_tile_class;
    logic [POS_W-1:0]       m_tile_column;
    logic [POS_W-1:0]       m_tile_row;
    logic [SUM_W-1:0]       m_tile_total;
    logic                   m_frame_done;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tile_scoreboard board = new();
    bit             steady = 1'b0;
    int             hold_asked = 0;
    int             hold_served = 0;
    int             stall_left = 0;
    int             pixels_sent = 0;
    int             cycle_count = 0;
    int             random_goal;

    tile_sum_three_level_classifier_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tile_class  (m_tile_class),
        .m_tile_column (m_tile_column),
        .m_tile_row    (m_tile_row),
        .m_tile_total  (m_tile_total),
        .m_frame_done  (m_frame_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 aclk = ~aclk;

    // result sink: check, then pick next ready
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready)
            board.check_tile(m_tile_class, m_tile_column, m_tile_row, m_tile_total,
                             m_frame_done);
        if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            stall_left  <= LONG_HOLD - 1;
            m_ready     <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [PIX_W-1:0] pick_pixel(pixel_mix_t mix);
        case (mix)
            MIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            MIX_DIM:     return PIX_W'($urandom_range(0, 15));
            MIX_FULL:    return 8'hFF;
            default:     return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [SUM_W-1:0] pick_threshold(int top);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return {SUM_W{1'b1}};
            2:       return SUM_W'($urandom);
            3:       return SUM_W'(SUM_CEILING);
            default: return SUM_W'($urandom_range(0, top));
        endcase
    endfunction

    task automatic wait_idle();
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        board.set_register(idx, d);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_sizes(input int tw, input int th, input int ta, input int td);
        program_reg(tscl_pkg::CFG_TILE_WIDTH, CFG_DATA_W'(tw));
        program_reg(tscl_pkg::CFG_TILE_HEIGHT, CFG_DATA_W'(th));
        program_reg(tscl_pkg::CFG_TILES_ACROSS, CFG_DATA_W'(ta));
        program_reg(tscl_pkg::CFG_TILES_DOWN, CFG_DATA_W'(td));
    endtask

    task automatic set_thresholds(input int lo, input int hi);
        program_reg(tscl_pkg::CFG_LOW_THRESHOLD, CFG_DATA_W'(lo));
        program_reg(tscl_pkg::CFG_HIGH_THRESHOLD, CFG_DATA_W'(hi));
    endtask

    // valid stays up across items unless this is the last one or a gap follows
    task automatic send_pixel(input logic [PIX_W-1:0] v, input bit last);
        int gap;
        gap = (!steady && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
        s_valid       <= 1'b1;
        s_pixel_value <= v;
        do @(posedge aclk); while (!s_ready);
        board.note_pixel(v);
        pixels_sent++;
        if (last || gap != 0) s_valid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    task automatic send_run(input int n, input pixel_mix_t mix);
        bit pause;
        for (int i = 0; i < n; i++) begin
            pause = !steady && i != n - 1 && $urandom_range(0, 40) == 0;
            send_pixel(pick_pixel(mix), i == n - 1 || pause);
            if (pause) wait_idle();
        end
        wait_idle();
    endtask

    task automatic random_phase();
        int         tw;
        int         th;
        int         ta;
        int         td;
        int         top;
        pixel_mix_t mix;
        tw = $urandom_range(1, 4);
        th = $urandom_range(1, 4);
        ta = $urandom_range(1, 6);
        td = $urandom_range(1, 3);
        if ($urandom_range(0, 7) == 0) tw = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
        if ($urandom_range(0, 7) == 0) th = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
        if ($urandom_range(0, 7) == 0) ta = $urandom_range(0, 1) ? 0 : $urandom_range(129, 255);
        if ($urandom_range(0, 7) == 0) td = $urandom_range(0, 1) ? 0 : $urandom_range(129, 255);
        if ($urandom_range(0, 3) != 0) program_reg(tscl_pkg::CFG_TILE_WIDTH, CFG_DATA_W'(tw));
        if ($urandom_range(0, 3) != 0) program_reg(tscl_pkg::CFG_TILE_HEIGHT, CFG_DATA_W'(th));
        if ($urandom_range(0, 3) != 0) program_reg(tscl_pkg::CFG_TILES_ACROSS, CFG_DATA_W'(ta));
        if ($urandom_range(0, 3) != 0) program_reg(tscl_pkg::CFG_TILES_DOWN, CFG_DATA_W'(td));
        top = 255 * board.tile_area();
        if ($urandom_range(0, 3) != 0)
            program_reg(tscl_pkg::CFG_LOW_THRESHOLD, pick_threshold(top));
        if ($urandom_range(0, 3) != 0)
            program_reg(tscl_pkg::CFG_HIGH_THRESHOLD, pick_threshold(top));
        if ($urandom_range(0, 5) == 0)
            program_reg($urandom_range(0, 1) ? CFG_SPARE_FIRST : CFG_SPARE_LAST,
                        CFG_DATA_W'($urandom));
        case ($urandom_range(0, 5))
            0:       mix = MIX_EXTREME;
            1:       mix = MIX_DIM;
            2:       mix = MIX_FULL;
            default: mix = MIX_RANDOM;
        endcase
        send_run($urandom_range(5, 80), mix);
    endtask

    initial begin
        s_valid       <= 1'b0;
        s_pixel_value <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        aresetn       <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one-pixel tiles, 2x2 grid: each class and both threshold edges
        set_sizes(1, 1, 2, 2);
        set_thresholds(100, 200);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd100, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd99, 1'b0);
        send_pixel(8'd201, 1'b1);
        wait_idle();

        // crossed thresholds: low test wins
        set_thresholds(200, 100);
        send_pixel(8'd150, 1'b0);
        send_pixel(8'd250, 1'b0);
        send_pixel(8'd50, 1'b1);
        wait_idle();

        // zero size registers clamp to one
        set_sizes(0, 0, 0, 0);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd8, 1'b1);
        wait_idle();

        // shrink sizes mid frame: counters past the new end wrap at once
        set_sizes(3, 1, 2, 1);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd2, 1'b1);
        wait_idle();
        program_reg(tscl_pkg::CFG_TILE_WIDTH, 20'd2);
        send_pixel(8'd3, 1'b1);
        wait_idle();
        program_reg(tscl_pkg::CFG_TILES_ACROSS, 20'd1);
        send_pixel(8'd4, 1'b0);
        send_pixel(8'd5, 1'b1);
        wait_idle();
        program_reg(CFG_SPARE_FIRST, 20'hFFFFF);
        program_reg(CFG_SPARE_LAST, 20'h5A5A5);

        // full-width row while the sink holds off: the block must back up
        set_sizes(1, 1, MAX_TILES_ACROSS, 1);
        set_thresholds($urandom_range(0, 255), $urandom_range(0, 255));
        hold_asked++;
        send_run(MAX_TILES_ACROSS, MIX_RANDOM);

        set_sizes(1, 1, 1, MAX_TILES_DOWN);
        send_run(MAX_TILES_DOWN, MIX_RANDOM);

        // widest tile at full scale
        set_sizes(MAX_TILE_SIDE, FULL_ROWS, 1, 1);
        set_thresholds(0, 255 * MAX_TILE_SIDE * FULL_ROWS - 1);
        send_run(MAX_TILE_SIDE * FULL_ROWS, MIX_FULL);

        random_goal = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < random_goal) begin
            steady = (random_goal - pixels_sent) < STEADY_TAIL;
            random_phase();
        end

        wait_idle();
        board.close();
        if (board.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== tile_sum_three_level_classifier_unit.f =====
sv/tscl_pkg.sv
sv/tscl_ram.sv
sv/tile_sum_three_level_classifier_unit.sv
tb/tile_sum_three_level_classifier_unit_test.sv
